>>> rtl/wdu_pkg.sv
// windowed downsampler: shared constants, register indexes, mode codes and lane control types
// no dependencies; compiled first

package wdu_pkg;

    localparam int LANES           = 4;
    localparam int SAMPLE_BITS     = 16;
    localparam int DEF_MAX_WINDOW  = 256;
    localparam int CFG_W           = 9;
    localparam int CFG_MAX         = 2**CFG_W - 1;
    localparam int IDX_W           = 2;
    localparam int SAMPLE_MAX      = 2**(SAMPLE_BITS - 1) - 1;
    localparam int SAMPLE_MIN      = -(2**(SAMPLE_BITS - 1));

    localparam logic [IDX_W-1:0] REG_SPREAD  = 2'd0;
    localparam logic [IDX_W-1:0] REG_DIVISOR = 2'd1;
    localparam logic [IDX_W-1:0] REG_MODE    = 2'd2;

    typedef enum logic [1:0] {
        MODE_MEAN = 2'd0,
        MODE_MAX  = 2'd1,
        MODE_MIN  = 2'd2,
        MODE_ZERO = 2'd3
    } mode_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic             load;
        logic             pick;
        logic             seed;
        logic             finish;
        logic             divide;
        mode_t            mode;
        logic [CFG_W-1:0] spread;
    } lane_ctrl_t;

endpackage

>>> rtl/wdu_if.sv
// windowed downsampler: valid/ready channel interfaces for sample frames and result frames
// depends on wdu_pkg

interface wdu_frame_if;
    import wdu_pkg::*;

    logic    valid;
    logic    ready;
    sample_t chan_a;
    sample_t chan_b;
    sample_t chan_c;
    sample_t chan_d;

    modport source (output valid, output chan_a, output chan_b, output chan_c, output chan_d,
                    input ready);
    modport sink   (input valid, input chan_a, input chan_b, input chan_c, input chan_d,
                    output ready);
endinterface

interface wdu_result_if;
    import wdu_pkg::*;

    logic    valid;
    logic    ready;
    sample_t out_a;
    sample_t out_b;
    sample_t out_c;
    sample_t out_d;

    modport source (output valid, output out_a, output out_b, output out_c, output out_d,
                    input ready);
    modport sink   (input valid, input out_a, input out_b, input out_c, input out_d,
                    output ready);
endinterface

>>> rtl/wdu_div.sv
// windowed downsampler: radix-2 restoring divider, signed dividend truncated toward zero
// depends on wdu_pkg

module wdu_div #(
    parameter int ACC_W = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [ACC_W-1:0]       dividend,
    input  logic [wdu_pkg::CFG_W-1:0]     divisor,
    output logic                          busy,
    output logic                          done,
    output logic signed [ACC_W-1:0]       quotient
);
    import wdu_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);

    logic [ACC_W-1:0] num_reg;
    logic [CFG_W:0]   rem_reg;
    logic [CFG_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [ACC_W-1:0] mag;
    logic [CFG_W:0]   rem_shift;
    logic             ge;
    logic [CFG_W:0]   rem_next;
    logic [ACC_W-1:0] num_next;

    assign mag       = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
    assign rem_shift = {rem_reg[CFG_W-1:0], num_reg[ACC_W-1]};
    assign ge        = rem_shift >= {1'b0, den_reg};
    assign rem_next  = ge ? rem_shift - {1'b0, den_reg} : rem_shift;
    assign num_next  = {num_reg[ACC_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ACC_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= mag;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[ACC_W-1];
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);

endmodule

>>> rtl/wdu_lane.sv
// windowed downsampler: one channel lane: pick, window accumulator with sum/max/min/zero and mean divider
// depends on wdu_pkg, wdu_div

module wdu_lane #(
    parameter int ACC_W = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wdu_pkg::lane_ctrl_t      ctrl,
    input  wdu_pkg::sample_t         sample,
    output logic signed [ACC_W-1:0]  result,
    output logic                     busy,
    output logic                     done
);
    import wdu_pkg::*;

    logic signed [ACC_W-1:0] accum_reg;
    logic signed [ACC_W-1:0] accum_next;
    logic signed [ACC_W-1:0] result_reg;
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] quotient;
    logic                    div_start;
    logic                    div_done;

    assign x         = ACC_W'(sample);
    assign div_start = ctrl.load && !ctrl.pick && ctrl.finish && ctrl.divide;

    always_comb
    begin
        accum_next = accum_reg;
        if (ctrl.seed)
        begin
            accum_next = (ctrl.mode == MODE_ZERO) ? '0 : x;
        end
        else
        begin
            case (ctrl.mode)
                MODE_MEAN: accum_next = accum_reg + x;
                MODE_MAX:
                begin
                    if (x > accum_reg)
                    begin
                        accum_next = x;
                    end
                end
                MODE_MIN:
                begin
                    if (x < accum_reg)
                    begin
                        accum_next = x;
                    end
                end
                default: accum_next = accum_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
        end
        else if (ctrl.load && !ctrl.pick)
        begin
            accum_reg <= accum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            if (ctrl.pick)
            begin
                result_reg <= x;
            end
            else if (ctrl.finish && !ctrl.divide)
            begin
                result_reg <= accum_next;
            end
        end
        else if (div_done)
        begin
            result_reg <= quotient;
        end
    end

    wdu_div #(
        .ACC_W (ACC_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (accum_next),
        .divisor  (ctrl.spread),
        .busy     (busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign result = result_reg;
    assign done   = div_done;

endmodule

>>> rtl/wdu_merge.sv
// windowed downsampler: merges lane results into one clipped result frame, output register
// depends on wdu_pkg, wdu_if

module wdu_merge #(
    parameter int ACC_W = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic signed [ACC_W-1:0]  lane_result [wdu_pkg::LANES],
    output logic                     pending,
    wdu_result_if.source             result
);
    import wdu_pkg::*;

    function automatic sample_t clip(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(SAMPLE_MAX);
        lo = ACC_W'(SAMPLE_MIN);
        if (v > hi)
        begin
            clip = sample_t'(SAMPLE_MAX);
        end
        else if (v < lo)
        begin
            clip = sample_t'(SAMPLE_MIN);
        end
        else
        begin
            clip = sample_t'(v[SAMPLE_BITS-1:0]);
        end
    endfunction

    logic    pending_reg;
    logic    valid_reg;
    logic    transfer;
    sample_t data_reg [LANES];

    assign transfer = pending_reg && (!valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (transfer)
            begin
                pending_reg <= 1'b0;
            end
            else if (load)
            begin
                pending_reg <= 1'b1;
            end

            if (transfer)
            begin
                valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (transfer)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                data_reg[k] <= clip(lane_result[k]);
            end
        end
    end

    assign pending      = pending_reg;
    assign result.valid = valid_reg;
    assign result.out_a = data_reg[0];
    assign result.out_b = data_reg[1];
    assign result.out_c = data_reg[2];
    assign result.out_d = data_reg[3];

endmodule

>>> rtl/windowed_downsampler_unit.sv
// windowed downsampler top level: period counter, register file, four lanes and result merge
// depends on wdu_pkg, wdu_if, wdu_div, wdu_lane, wdu_merge
//
// usage
// - frame: one transaction carries one sample frame of four signed 16-bit channels
// - result: one transaction carries one combined frame; at most one per period of divisor
//   frames, given when the last frame of the window (position spread-1, or 0 for spread 0) is taken
// - registers spread, divisor and mode are written through wr_en/wr_index/wr_data while
//   the block is idle; the user must keep to this, as the block itself does not enforce it;
//   divisor is clamped to 1..min(MAX_WINDOW, CFG_MAX) and spread to the clamped divisor
// - a pick, max or min result goes from the lane result register to the output register; a
//   mean result first passes through the per-lane one-bit-per-cycle divider
// - throughput: one frame per cycle inside a window while frame.ready is high; the frame that
//   closes a window holds frame.ready low until its result has passed to the output register
// - a finished result waits in the output register while the next frames are taken; a
//   second result waits in the lanes and holds frame.ready low until the first is taken
// - reset: registers return to spread 1, divisor 2, mode mean; period position is zero,
//   no result is pending and frame.ready is high

module windowed_downsampler_unit #(
    parameter int MAX_WINDOW = wdu_pkg::DEF_MAX_WINDOW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    wdu_frame_if.sink                   frame,
    wdu_result_if.source                result,
    input  logic                        wr_en,
    input  logic [wdu_pkg::IDX_W-1:0]   wr_index,
    input  logic [wdu_pkg::CFG_W-1:0]   wr_data
);
    import wdu_pkg::*;

    localparam int CAP     = (MAX_WINDOW > CFG_MAX) ? CFG_MAX : MAX_WINDOW;
    localparam int PHASE_W = $clog2(CAP);
    localparam int ACC_W   = SAMPLE_BITS + $clog2(CAP);

    logic [CFG_W-1:0]   spread_reg;
    logic [CFG_W-1:0]   divisor_reg;
    mode_t              mode_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    logic [CFG_W-1:0]   div_eff;
    logic [CFG_W-1:0]   spr_eff;
    logic [CFG_W-1:0]   p_ext;
    logic [CFG_W:0]     p_inc;
    logic               wrap;
    logic               pick;
    logic               in_win;
    logic               accept;
    logic               pending;
    lane_ctrl_t         ctrl;
    logic               res_load;

    sample_t                 samples     [LANES];
    logic signed [ACC_W-1:0] lane_result [LANES];
    logic [LANES-1:0]        lane_busy;
    logic [LANES-1:0]        lane_done;

    always_comb
    begin
        if (divisor_reg == '0)
        begin
            div_eff = CFG_W'(1);
        end
        else if (divisor_reg > CFG_W'(CAP))
        begin
            div_eff = CFG_W'(CAP);
        end
        else
        begin
            div_eff = divisor_reg;
        end
    end

    assign spr_eff = (spread_reg > div_eff) ? div_eff : spread_reg;
    assign p_ext   = CFG_W'(phase_reg);
    assign p_inc   = {1'b0, p_ext} + 1'b1;
    assign wrap    = p_inc >= {1'b0, div_eff};
    assign pick    = spr_eff < CFG_W'(2);
    assign in_win  = p_ext < spr_eff;
    assign accept  = frame.valid && frame.ready;

    assign frame.ready = !(|lane_busy) && !(|lane_done) && !pending;

    always_comb
    begin
        ctrl.load   = accept && (pick ? (phase_reg == '0) : in_win);
        ctrl.pick   = pick;
        ctrl.seed   = phase_reg == '0;
        ctrl.finish = p_ext == spr_eff - 1'b1;
        ctrl.divide = mode_reg == MODE_MEAN;
        ctrl.mode   = mode_reg;
        ctrl.spread = spr_eff;
    end

    assign res_load   = (ctrl.load && (ctrl.pick || (ctrl.finish && !ctrl.divide)))
                        || (&lane_done);
    assign phase_next = wrap ? '0 : PHASE_W'(p_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_reg  <= CFG_W'(1);
            divisor_reg <= CFG_W'(2);
            mode_reg    <= MODE_MEAN;
            phase_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_SPREAD:  spread_reg  <= wr_data;
                    REG_DIVISOR: divisor_reg <= wr_data;
                    REG_MODE:    mode_reg    <= mode_t'(wr_data[1:0]);
                    default:     ;
                endcase
            end
            if (accept)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    assign samples[0] = frame.chan_a;
    assign samples[1] = frame.chan_b;
    assign samples[2] = frame.chan_c;
    assign samples[3] = frame.chan_d;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        wdu_lane #(
            .ACC_W (ACC_W)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .sample (samples[k]),
            .result (lane_result[k]),
            .busy   (lane_busy[k]),
            .done   (lane_done[k])
        );
    end

    wdu_merge #(
        .ACC_W (ACC_W)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (res_load),
        .lane_result (lane_result),
        .pending     (pending),
        .result      (result)
    );

endmodule

>>> rtl/wdu_checker.sv
// windowed downsampler: port-level checks over time, bound to the top level
// depends on wdu_pkg, windowed_downsampler_unit

module wdu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             frame_valid,
    input logic             frame_ready,
    input logic             result_valid,
    input logic             result_ready,
    input wdu_pkg::sample_t out_a,
    input wdu_pkg::sample_t out_b,
    input wdu_pkg::sample_t out_c,
    input wdu_pkg::sample_t out_d
);
    import wdu_pkg::*;

    // frame.ready only drops after a transaction on the frame channel
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(frame_ready) |-> $past(frame_valid && frame_ready))
        else $error("frame ready dropped without a frame transaction");

    // a new result is always preceded by a cycle with frame intake held off
    a_result_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(frame_ready))
        else $error("result appeared without a pending result stage");

    // a stalled result keeps its value until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_a) && $stable(out_b)
            && $stable(out_c) && $stable(out_d))
        else $error("stalled result changed");

endmodule

bind windowed_downsampler_unit wdu_checker u_wdu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame.valid),
    .frame_ready  (frame.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .out_a        (result.out_a),
    .out_b        (result.out_b),
    .out_c        (result.out_c),
    .out_d        (result.out_d)
);

>>> tb/sv/testbench.sv
// self-checking testbench for windowed_downsampler_unit: drives sample frames through
// random gaps, predicts each window result and checks every result frame lane by lane
// depends on wdu_pkg, wdu_if and the rtl of windowed_downsampler_unit

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wdu_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int MAX_WINDOW    = DEF_MAX_WINDOW;
    localparam int ACC_W         = 24;
    localparam int ITEM_TARGET   = 1900;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 250;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef logic [LANES-1:0][SAMPLE_BITS-1:0] frame_bits_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_index;
    logic [CFG_W-1:0]     wr_data;

    wdu_frame_if  frame_ch ();
    wdu_result_if result_ch ();

    windowed_downsampler_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // predictor state
    logic [CFG_W-1:0]          cfg_spread;
    logic [CFG_W-1:0]          cfg_divisor;
    mode_t                     cfg_mode;
    logic [7:0]                phase_pos;
    logic signed [ACC_W-1:0]   lane_acc [LANES];

    frame_bits_t pending_frames [$];
    frame_bits_t window_results [$];

    int    frames_pushed = 0;
    int    frames_taken  = 0;
    int    results_seen  = 0;
    int    reg_writes    = 0;
    int    phases_run    = 0;
    int    errors        = 0;
    int    cycle_count   = 0;
    logic  frame_fire    = 1'b0;

    int    send_gap      = 0;
    int    send_calm     = 0;
    int    stall_left    = 0;
    int    recv_calm     = 0;
    int    hold_left     = 0;
    int    next_hold_at  = 300;
    int    recv_roll;

    string lane_names [LANES] = '{"out_a", "out_b", "out_c", "out_d"};

    function automatic sample_t clip_sample(int v);
        if (v > SAMPLE_MAX)
        begin
            return sample_t'(SAMPLE_MAX);
        end
        if (v < SAMPLE_MIN)
        begin
            return sample_t'(SAMPLE_MIN);
        end
        return sample_t'(v);
    endfunction

    // one frame into the window state; returns 1 when a result frame is due
    function automatic bit downsample_step(input frame_bits_t smp, output frame_bits_t res);
        int eff_div;
        int eff_spr;
        int pos;
        int x;
        int q;
        bit made;
        made    = 1'b0;
        res     = '0;
        eff_div = cfg_divisor;
        if (eff_div == 0)
        begin
            eff_div = 1;
        end
        if (eff_div > MAX_WINDOW)
        begin
            eff_div = MAX_WINDOW;
        end
        eff_spr = (cfg_spread > eff_div) ? eff_div : cfg_spread;
        pos     = phase_pos;
        if (eff_spr <= 1)
        begin
            if (pos == 0)
            begin
                res  = smp;
                made = 1'b1;
            end
        end
        else if (pos < eff_spr)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                x = sample_t'(smp[k]);
                if (pos == 0)
                begin
                    lane_acc[k] = (cfg_mode == MODE_ZERO) ? '0 : ACC_W'(x);
                end
                else
                begin
                    case (cfg_mode)
                        MODE_MEAN: lane_acc[k] = lane_acc[k] + ACC_W'(x);
                        MODE_MAX:
                        begin
                            if (x > lane_acc[k])
                            begin
                                lane_acc[k] = ACC_W'(x);
                            end
                        end
                        MODE_MIN:
                        begin
                            if (x < lane_acc[k])
                            begin
                                lane_acc[k] = ACC_W'(x);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (pos == eff_spr - 1)
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    q = lane_acc[k];
                    if (cfg_mode == MODE_MEAN)
                    begin
                        q = q / eff_spr;
                    end
                    res[k] = clip_sample(q);
                end
                made = 1'b1;
            end
        end
        phase_pos = (pos + 1 >= eff_div) ? 8'd0 : 8'(pos + 1);
        return made;
    endfunction

    function automatic frame_bits_t make_frame(int a, int b, int c, int d);
        frame_bits_t f;
        f[0] = sample_t'(a);
        f[1] = sample_t'(b);
        f[2] = sample_t'(c);
        f[3] = sample_t'(d);
        return f;
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0:       return sample_t'(SAMPLE_MAX);
            1:       return sample_t'(SAMPLE_MIN);
            2:       return sample_t'(-$urandom_range(0, 1));
            3:       return sample_t'($urandom_range(0, 200) - 100);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic push_frame(input frame_bits_t f);
        pending_frames.push_back(f);
        frames_pushed++;
    endtask

    task automatic push_random_frames(int count);
        repeat (count)
        begin
            push_frame({random_sample(), random_sample(), random_sample(), random_sample()});
        end
    endtask

    // waits until every frame is taken and every window result has come back
    task automatic drain();
        while (frames_taken != frames_pushed || window_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= CFG_W'(value);
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    task automatic set_config(int spr, int div, mode_t md);
        drain();
        write_reg(REG_SPREAD, spr);
        write_reg(REG_DIVISOR, div);
        write_reg(REG_MODE, int'(md));
        phases_run++;
    endtask

    // sample side: prediction, checking and counters
    always @(posedge clk)
    begin
        frame_bits_t want;
        frame_bits_t got;
        if (!rst_n)
        begin
            cfg_spread  = CFG_W'(1);
            cfg_divisor = CFG_W'(2);
            cfg_mode    = MODE_MEAN;
            phase_pos   = '0;
            for (int k = 0; k < LANES; k++)
            begin
                lane_acc[k] = '0;
            end
            frame_fire <= 1'b0;
        end
        else
        begin
            frame_fire <= frame_ch.valid && frame_ch.ready;
            if (wr_en)
            begin
                reg_writes++;
                case (wr_index)
                    REG_SPREAD:  cfg_spread  = wr_data;
                    REG_DIVISOR: cfg_divisor = wr_data;
                    REG_MODE:    cfg_mode    = mode_t'(wr_data[1:0]);
                    default: ;
                endcase
            end
            if (frame_ch.valid && frame_ch.ready)
            begin
                frames_taken++;
                if (downsample_step({frame_ch.chan_d, frame_ch.chan_c,
                                     frame_ch.chan_b, frame_ch.chan_a}, want))
                begin
                    window_results.push_back(want);
                end
            end
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                got = {result_ch.out_d, result_ch.out_c, result_ch.out_b, result_ch.out_a};
                if (window_results.size() == 0)
                begin
                    $error("result transaction with no window result expected");
                    errors++;
                end
                else
                begin
                    want = window_results.pop_front();
                    for (int k = 0; k < LANES; k++)
                    begin
                        if (want[k] !== got[k])
                        begin
                            $error("%s: expected %0d, actual %0d", lane_names[k],
                                   sample_t'(want[k]), sample_t'(got[k]));
                            errors++;
                        end
                    end
                end
            end
        end
    end

    // frame driver
    always @(negedge clk)
    begin
        frame_bits_t nxt;
        if (!rst_n)
        begin
            frame_ch.valid <= 1'b0;
        end
        else if (!frame_ch.valid || frame_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                frame_ch.valid <= 1'b0;
            end
            else if (pending_frames.size() != 0)
            begin
                nxt = pending_frames.pop_front();
                frame_ch.valid  <= 1'b1;
                frame_ch.chan_a <= nxt[0];
                frame_ch.chan_b <= nxt[1];
                frame_ch.chan_c <= nxt[2];
                frame_ch.chan_d <= nxt[3];
                if (send_calm > 0)
                begin
                    send_calm--;
                end
                else
                begin
                    if ($urandom_range(0, 99) == 0)
                    begin
                        send_calm = $urandom_range(40, 120);
                    end
                    send_gap = pick_gap();
                end
            end
            else
            begin
                frame_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and a long hold-off while frames keep coming
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (frames_taken >= next_hold_at && frames_pushed > frames_taken)
        begin
            hold_left = LONG_HOLD - 1;
            next_hold_at += 900;
            result_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if (recv_calm > 0)
        begin
            recv_calm--;
            result_ch.ready <= 1'b1;
        end
        else
        begin
            recv_roll = $urandom_range(0, 99);
            if (recv_roll == 0)
            begin
                recv_calm = $urandom_range(40, 150);
                result_ch.ready <= 1'b1;
            end
            else if (recv_roll < 75)
            begin
                result_ch.ready <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left == 0)
                begin
                    result_ch.ready <= 1'b1;
                end
                else
                begin
                    stall_left--;
                    result_ch.ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        int div;
        int eff;
        int spr;
        int count;
        rst_n           = 1'b0;
        wr_en           = 1'b0;
        wr_index        = '0;
        wr_data         = '0;
        frame_ch.valid  = 1'b0;
        frame_ch.chan_a = '0;
        frame_ch.chan_b = '0;
        frame_ch.chan_c = '0;
        frame_ch.chan_d = '0;
        result_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: pick the first frame of every pair
        push_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN, 0, -1));
        push_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX, -1, 0));
        push_frame(make_frame(1, -2, 16'h5555, 16'hAAAA));
        push_frame(make_frame(16'hAAAA, 16'h5555, -2, 1));

        // mean at full scale and truncation toward zero
        set_config(3, 3, MODE_MEAN);
        push_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN, -1, 1));
        push_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN, -1, 1));
        push_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN, 0, 0));

        set_config(2, 3, MODE_MAX);
        push_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX, -5, 7));
        push_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN, -3, 9));
        push_frame(make_frame(0, 0, 100, -100));

        set_config(2, 2, MODE_MIN);
        push_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN, -5, 7));
        push_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX, -3, 9));

        // zero mode, spread above divisor
        set_config(5, 2, MODE_ZERO);
        push_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN, 123, -321));
        push_frame(make_frame(-1, 1, SAMPLE_MAX, SAMPLE_MIN));

        // divisor zero, spread zero
        set_config(0, 0, MODE_MAX);
        push_frame(make_frame(7, -7, SAMPLE_MAX, SAMPLE_MIN));
        push_frame(make_frame(-8, 8, SAMPLE_MIN, SAMPLE_MAX));

        // leave the counter deep in a period, then shrink the divisor below it
        set_config(4, 8, MODE_MAX);
        push_frame(make_frame(1, 2, 3, 4));
        push_frame(make_frame(-1, -2, -3, -4));
        push_frame(make_frame(SAMPLE_MAX, 0, SAMPLE_MIN, 0));
        push_frame(make_frame(5, SAMPLE_MAX, 5, SAMPLE_MIN));
        push_frame(make_frame(9, 9, 9, 9));
        set_config(2, 2, MODE_MIN);
        push_frame(make_frame(11, 12, 13, 14));
        push_frame(make_frame(SAMPLE_MIN, 20, SAMPLE_MAX, -20));
        push_frame(make_frame(30, SAMPLE_MIN, -30, SAMPLE_MAX));

        // largest window: divisor above the maximum, mean over a full-scale sum
        set_config(CFG_MAX, CFG_MAX, MODE_MEAN);
        repeat (MAX_WINDOW)
        begin
            push_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
        end
        push_random_frames(5);

        while (frames_pushed < ITEM_TARGET)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                div = $urandom_range(200, CFG_MAX);
                eff = (div > MAX_WINDOW) ? MAX_WINDOW : div;
                case ($urandom_range(0, 3))
                    0:       spr = div;
                    1:       spr = $urandom_range(0, 1);
                    default: spr = $urandom_range(2, CFG_MAX);
                endcase
                count = eff + $urandom_range(0, 8);
            end
            else
            begin
                div = $urandom_range(0, 12);
                if ($urandom_range(0, 7) == 0)
                begin
                    spr = $urandom_range(0, CFG_MAX);
                end
                else
                begin
                    spr = $urandom_range(0, div + 2);
                end
                count = $urandom_range(15, 70);
            end
            set_config(spr, div, mode_t'($urandom_range(0, 3)));
            push_random_frames(count);
        end

        drain();
        $display("covered %0d frames and %0d result frames over %0d register settings",
                 frames_taken, results_seen, phases_run);
        $display("%0d register writes, %0d mismatches", reg_writes, errors);
        if (errors == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
